@@ hw/rtl/npq_pkg.sv @@
package npq_pkg;

   localparam int PALETTE_SIZE = 6;
   localparam int PALETTE_REGS = 6;
   localparam int NUM_PAIRS    = (PALETTE_SIZE + 1) / 2;
   localparam int CHAN_W       = 8;
   localparam int NUM_CHAN     = 3;
   localparam int RGB_W        = NUM_CHAN * CHAN_W;
   localparam int SQ_W         = 2 * CHAN_W;
   localparam int DIST_W       = SQ_W + 2;
   localparam int IDX_W        = 3;
   localparam int CSR_IDX_W    = 3;

   localparam logic [CHAN_W-1:0]    NEUTRAL_SPREAD    = 8'd20;
   localparam logic [CHAN_W-1:0]    ALPHA_OPAQUE      = 8'hff;
   localparam logic [IDX_W-1:0]     NEUTRAL_LIMIT_RST = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL_LIMIT = 3'd6;

   typedef logic [RGB_W-1:0] rgb_type;
   typedef rgb_type [PALETTE_REGS-1:0] palette_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
   } req_word_type;

   typedef struct packed {
      logic [31:0]      argb_out;
      logic [IDX_W-1:0] palette_index;
      logic             is_neutral;
   } rsp_word_type;

   typedef struct packed {
      logic [DIST_W-1:0] dist_sq;
      logic [IDX_W-1:0]  idx;
      logic              cand;
   } cand_type;

   typedef cand_type [PALETTE_SIZE-1:0] cand_vec_type;
   typedef cand_type [NUM_PAIRS-1:0]    pair_vec_type;

   // lower-index operand a wins ties
   function automatic cand_type pick(input cand_type a, input cand_type b);
      cand_type r;
      if (a.cand && (!b.cand || (a.dist_sq <= b.dist_sq))) begin
         r = a;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/npq_csr.sv @@
module npq_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [npq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [npq_pkg::RGB_W-1:0]     csr_data,
   output npq_pkg::palette_type          palette,
   output logic [npq_pkg::IDX_W-1:0]     neutral_limit
);

   npq_pkg::palette_type              palette_ff;
   logic [npq_pkg::IDX_W-1:0]         limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff <= '0;
         limit_ff   <= npq_pkg::NEUTRAL_LIMIT_RST;
      end else if (csr_valid) begin
         for (int i = 0; i < npq_pkg::PALETTE_REGS; i++) begin
            if (csr_index == npq_pkg::CSR_IDX_W'(i)) begin
               palette_ff[i] <= csr_data;
            end
         end
         if (csr_index == npq_pkg::REG_NEUTRAL_LIMIT) begin
            limit_ff <= csr_data[npq_pkg::IDX_W-1:0];
         end
      end
   end

   assign palette       = palette_ff;
   assign neutral_limit = limit_ff;

endmodule

@@ hw/rtl/npq_dist.sv @@
module npq_dist (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  npq_pkg::req_word_type     in_word,
   input  npq_pkg::palette_type      palette,
   input  logic [npq_pkg::IDX_W-1:0] neutral_limit,
   output logic                      out_valid,
   input  logic                      out_ready,
   output npq_pkg::cand_vec_type     out_cand,
   output logic                      out_neutral
);

   localparam int P = npq_pkg::PALETTE_SIZE;
   localparam int C = npq_pkg::NUM_CHAN;
   localparam int W = npq_pkg::CHAN_W;

   logic [C-1:0][W-1:0]                chan;
   logic [W-1:0]                       hi, lo, spread;
   logic                               neutral;
   logic [P-1:0][C-1:0][W-1:0]         d1_in;
   logic [P-1:0]                       cand1_in;

   logic                               v1_ff, v2_ff, v3_ff;
   logic                               en1, en2, en3;
   logic [P-1:0][C-1:0][W-1:0]         d1_ff;
   logic [P-1:0]                       cand1_ff, cand2_ff;
   logic                               neu1_ff, neu2_ff, neu3_ff;
   logic [P-1:0][C-1:0][npq_pkg::SQ_W-1:0] sq2_in, sq2_ff;
   npq_pkg::cand_vec_type              c3_in, c3_ff;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // stage 1: spread test and per-channel distances
   always_comb begin
      chan[0] = in_word.red_in;
      chan[1] = in_word.green_in;
      chan[2] = in_word.blue_in;
      hi = chan[0];
      lo = chan[0];
      for (int c = 1; c < C; c++) begin
         if (chan[c] > hi) hi = chan[c];
         if (chan[c] < lo) lo = chan[c];
      end
      spread  = hi - lo;
      neutral = spread < npq_pkg::NEUTRAL_SPREAD;
      for (int i = 0; i < P; i++) begin
         cand1_in[i] = !neutral || (npq_pkg::IDX_W'(i) <= neutral_limit) || (i == 0);
         for (int c = 0; c < C; c++) begin
            if (chan[c] > palette[i][(C-1-c)*W +: W]) begin
               d1_in[i][c] = chan[c] - palette[i][(C-1-c)*W +: W];
            end else begin
               d1_in[i][c] = palette[i][(C-1-c)*W +: W] - chan[c];
            end
         end
      end
   end

   // stage 2: squares
   always_comb begin
      for (int i = 0; i < P; i++) begin
         for (int c = 0; c < C; c++) begin
            sq2_in[i][c] = d1_ff[i][c] * d1_ff[i][c];
         end
      end
   end

   // stage 3: distance sums
   always_comb begin
      for (int i = 0; i < P; i++) begin
         c3_in[i].dist_sq = {2'b00, sq2_ff[i][0]} + {2'b00, sq2_ff[i][1]}
                          + {2'b00, sq2_ff[i][2]};
         c3_in[i].idx     = npq_pkg::IDX_W'(i);
         c3_in[i].cand    = cand2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         d1_ff    <= d1_in;
         cand1_ff <= cand1_in;
         neu1_ff  <= neutral;
      end
      if (en2) begin
         sq2_ff   <= sq2_in;
         cand2_ff <= cand1_ff;
         neu2_ff  <= neu1_ff;
      end
      if (en3) begin
         c3_ff    <= c3_in;
         neu3_ff  <= neu2_ff;
      end
   end

   assign out_valid   = v3_ff;
   assign out_cand    = c3_ff;
   assign out_neutral = neu3_ff;

endmodule

@@ hw/rtl/npq_select.sv @@
module npq_select (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  npq_pkg::cand_vec_type in_cand,
   input  logic                  in_neutral,
   input  npq_pkg::palette_type  palette,
   output logic                  out_valid,
   input  logic                  out_ready,
   output npq_pkg::rsp_word_type out_word
);

   localparam int P  = npq_pkg::PALETTE_SIZE;
   localparam int NP = npq_pkg::NUM_PAIRS;

   logic                  v4_ff, vo_ff;
   logic                  en4, eno;
   npq_pkg::pair_vec_type p4_in, p4_ff;
   logic                  neu4_ff;
   npq_pkg::cand_type     best;
   npq_pkg::rsp_word_type o_in, o_ff;

   assign eno      = !vo_ff || out_ready;
   assign en4      = !v4_ff || eno;
   assign in_ready = en4;

   // stage 4: pairwise reduce
   always_comb begin
      for (int k = 0; k < NP; k++) begin
         if (2 * k + 1 < P) begin
            p4_in[k] = npq_pkg::pick(in_cand[2*k], in_cand[2*k+1]);
         end else begin
            p4_in[k] = in_cand[2*k];
         end
      end
   end

   // stage 5: final reduce and palette lookup
   always_comb begin
      best = p4_ff[0];
      for (int k = 1; k < NP; k++) begin
         best = npq_pkg::pick(best, p4_ff[k]);
      end
      o_in.argb_out      = {npq_pkg::ALPHA_OPAQUE, palette[best.idx]};
      o_in.palette_index = best.idx;
      o_in.is_neutral    = neu4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en4) v4_ff <= in_valid;
         if (eno) vo_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         p4_ff   <= p4_in;
         neu4_ff <= in_neutral;
      end
      if (eno) begin
         o_ff <= o_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_word  = o_ff;

endmodule

@@ hw/rtl/nearest_palette_quantiser.sv @@
// channel   direction  handshake              word
// req       in         req_valid/req_ready    req_data (red, green, blue)
// rsp       out        rsp_valid/rsp_ready    rsp_data (argb, index, neutral flag)
// csr       in         csr_valid/csr_ready    csr_index, csr_data
//
// One pixel per clock while rsp_ready is high.
// Five register stages: channel distances, squares, sums, pair compare,
// final compare with palette lookup into the output register.
// Synchronous reset clears all valid bits; palette to 0, neutral limit to 1.
// A stall holds only the stages that are full; bubbles collapse.
// csr_ready is always high; writes take effect the next cycle.
module nearest_palette_quantiser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  npq_pkg::req_word_type         req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output npq_pkg::rsp_word_type         rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [npq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [npq_pkg::RGB_W-1:0]     csr_data
);

   npq_pkg::palette_type          palette;
   logic [npq_pkg::IDX_W-1:0]     neutral_limit;
   logic                          mid_valid, mid_ready, mid_neutral;
   npq_pkg::cand_vec_type         mid_cand;

   npq_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .palette       (palette),
      .neutral_limit (neutral_limit)
   );

   npq_dist u_dist (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_word       (req_data),
      .palette       (palette),
      .neutral_limit (neutral_limit),
      .out_valid     (mid_valid),
      .out_ready     (mid_ready),
      .out_cand      (mid_cand),
      .out_neutral   (mid_neutral)
   );

   npq_select u_select (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_cand    (mid_cand),
      .in_neutral (mid_neutral),
      .palette    (palette),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_word   (rsp_data)
   );

endmodule
